>>> hw/rtl/ibcc_pkg.sv
// ----------------------------------------------------------------------------
// ibcc_pkg
// Shared types, constants and the symbol classifier for the base composition
// counter.
// ----------------------------------------------------------------------------
package ibcc_pkg;

  localparam int unsigned CountBits    = 32;
  localparam int unsigned CountOutBits = 32;
  localparam int unsigned NumColumns   = 18;
  localparam int unsigned ColBits      = 5;
  localparam int unsigned SymBits      = 8;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QPtrBits     = $clog2(QueueDepth);

  localparam logic [ColBits-1:0] ColLength = ColBits'(0);
  localparam logic [ColBits-1:0] ColOther  = ColBits'(NumColumns - 1);

  localparam logic [SymBits-1:0] LowerA    = 8'h61;
  localparam logic [SymBits-1:0] LowerZ    = 8'h7a;
  localparam logic [SymBits-1:0] CaseShift = 8'd32;

  typedef enum logic [1:0] {
    CmdChar    = 2'd0,
    CmdEnd     = 2'd1,
    CmdMissing = 2'd2,
    CmdUnused  = 2'd3
  } cmd_e;

  typedef enum logic {
    StIdle = 1'b0,
    StDump = 1'b1
  } back_state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [ColBits-1:0] column;
  } q_entry_t;

  // Fold lowercase, then map to the IUPAC column.
  function automatic logic [ColBits-1:0] classify(input logic [SymBits-1:0] sym);
    logic [SymBits-1:0] c;
    logic [ColBits-1:0] col;
    c = sym;
    if (c >= LowerA && c <= LowerZ) begin
      c = c - CaseShift;
    end
    unique case (c)
      "A":     col = ColBits'(1);
      "C":     col = ColBits'(2);
      "G":     col = ColBits'(3);
      "T":     col = ColBits'(4);
      "S":     col = ColBits'(5);
      "W":     col = ColBits'(6);
      "M":     col = ColBits'(7);
      "K":     col = ColBits'(8);
      "R":     col = ColBits'(9);
      "Y":     col = ColBits'(10);
      "V":     col = ColBits'(11);
      "H":     col = ColBits'(12);
      "D":     col = ColBits'(13);
      "B":     col = ColBits'(14);
      "N":     col = ColBits'(15);
      "I":     col = ColBits'(16);
      default: col = ColOther;
    endcase
    return col;
  endfunction

endpackage

>>> hw/rtl/ibcc_front.sv
// ----------------------------------------------------------------------------
// ibcc_front
// Accepts input items, classifies the symbol and pushes work into the queue.
// ----------------------------------------------------------------------------
module ibcc_front import ibcc_pkg::*; (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [SymBits-1:0] symbol_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output q_entry_t           q_entry_o
);

  cmd_e cmd;

  assign cmd        = cmd_e'(command_i);
  assign in_ready_o = ~q_full_i;

  // Drop unused commands: accepted, never queued.
  assign q_push_o         = in_valid_i & ~q_full_i & (cmd != CmdUnused);
  assign q_entry_o.cmd    = cmd;
  assign q_entry_o.column = classify(symbol_i);

endmodule

>>> hw/rtl/ibcc_queue.sv
// ----------------------------------------------------------------------------
// ibcc_queue
// Short FIFO between the classifying front and the counting back.
// ----------------------------------------------------------------------------
module ibcc_queue import ibcc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t entry_o
);

  q_entry_t            mem_q [QueueDepth];
  logic [QPtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrBits:0]   fill_q, fill_d;
  logic                do_push, do_pop;

  assign full_o  = (fill_q == (QPtrBits+1)'(QueueDepth));
  assign valid_o = (fill_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrBits'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QPtrBits'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + (QPtrBits+1)'(1);
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - (QPtrBits+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> hw/rtl/ibcc_back.sv
// ----------------------------------------------------------------------------
// ibcc_back
// Holds the class counters, bumps them per character and dumps a run of
// column results through an output register.
// ----------------------------------------------------------------------------
module ibcc_back import ibcc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  q_entry_t                q_entry_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ColBits-1:0]      column_o,
  output logic [CountOutBits-1:0] count_o,
  output logic                    is_missing_o,
  output logic                    last_o
);

  back_state_e state_q, state_d;

  logic [CountBits-1:0]    cnt_q [NumColumns];
  logic [ColBits-1:0]      idx_q, idx_d;
  logic                    miss_q, miss_d;

  logic                    out_valid_q, out_valid_d;
  logic [ColBits-1:0]      out_col_q;
  logic [CountOutBits-1:0] out_cnt_q;
  logic                    out_miss_q;
  logic                    out_last_q;

  logic                    load;
  logic                    idx_last;
  logic                    bump;
  logic                    clear;
  logic [CountBits-1:0]    rd_cnt;
  logic [CountOutBits-1:0] rd_cnt_out;

  assign load     = (state_q == StDump) & (~out_valid_q | out_ready_i);
  assign idx_last = (idx_q == ColOther);
  assign rd_cnt   = cnt_q[idx_q];

  generate
    if (CountBits >= CountOutBits) begin : g_trunc
      assign rd_cnt_out = rd_cnt[CountOutBits-1:0];
    end else begin : g_ext
      assign rd_cnt_out = {{(CountOutBits-CountBits){1'b0}}, rd_cnt};
    end
  endgenerate

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i && q_entry_i.cmd != CmdChar) begin
          state_d = StDump;
        end
      end
      StDump: begin
        if (load && idx_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop_o     = 1'b0;
    bump        = 1'b0;
    clear       = 1'b0;
    idx_d       = idx_q;
    miss_d      = miss_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      StIdle: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          if (q_entry_i.cmd == CmdChar) begin
            bump = 1'b1;
          end else begin
            idx_d  = ColLength;
            miss_d = (q_entry_i.cmd == CmdMissing);
          end
        end
      end
      StDump: begin
        if (load) begin
          out_valid_d = 1'b1;
          idx_d       = idx_q + ColBits'(1);
          clear       = idx_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      idx_q       <= ColLength;
      miss_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      miss_q      <= miss_d;
    end
  end

  // Saturating counters: length and the symbol's class bump together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumColumns; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NumColumns; i++) begin
        if (clear) begin
          cnt_q[i] <= '0;
        end else if (bump && (ColBits'(i) == ColLength || ColBits'(i) == q_entry_i.column)
                     && cnt_q[i] != {CountBits{1'b1}}) begin
          cnt_q[i] <= cnt_q[i] + CountBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_col_q  <= idx_q;
      out_cnt_q  <= miss_q ? '0 : rd_cnt_out;
      out_miss_q <= miss_q;
      out_last_q <= idx_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign column_o     = out_col_q;
  assign count_o      = out_cnt_q;
  assign is_missing_o = out_miss_q;
  assign last_o       = out_last_q;

endmodule

>>> hw/rtl/iupac_base_composition_counter.sv
// ----------------------------------------------------------------------------
// iupac_base_composition_counter
// Streaming IUPAC nucleotide composition counter with an 18-column report.
// ----------------------------------------------------------------------------
// Feed one sequence byte per item (command 0); lowercase letters fold to
// uppercase, every byte adds to the length and to one of the classes
// A C G T S W M K R Y V H D B N I or "other". An end item (command 1) reports
// the 18 counts, length first, one result per cycle while out_ready_i is high,
// with last set on the final column, then clears the counters; a missing item
// (command 2) reports 18 zero counts flagged missing and also clears. Command
// 3 is accepted and dropped. Counters saturate at their maximum. Character
// items flow at one per cycle while the back end is idle. An end or missing
// item holds the counter back end while it is popped from the queue and its
// 18 columns are dumped, paced by the single output register; a four-entry
// queue behind the classifier keeps accepting bytes meanwhile until it fills.
module iupac_base_composition_counter import ibcc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              command_i,
  input  logic [SymBits-1:0]      symbol_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ColBits-1:0]      column_o,
  output logic [CountOutBits-1:0] count_o,
  output logic                    is_missing_o,
  output logic                    last_o
);

  logic     q_full;
  logic     q_push;
  q_entry_t q_wr_entry;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_rd_entry;

  // Classify and enqueue.
  ibcc_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .symbol_i   (symbol_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_wr_entry)
  );

  // Decouple front from back.
  ibcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_rd_entry)
  );

  // Count and report.
  ibcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_rd_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .column_o     (column_o),
    .count_o      (count_o),
    .is_missing_o (is_missing_o),
    .last_o       (last_o)
  );

endmodule
